[rtl/fgn_pkg.sv]
// shared types, constants and arithmetic helpers for the fractal gradient noise block
`timescale 1ns / 1ps
package fgn_pkg;

  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int AMP_W     = 17;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 8;
  localparam int Q_W       = 17;

  localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 8'd2;

  localparam logic [AMP_W-1:0] AMP_ONE    = 17'h10000;
  localparam logic [17:0]      FADE_THREE = 18'd196608;
  localparam logic [Q_W-1:0]   Q_LIMIT    = 17'd32768;

  typedef struct packed {
    logic [31:0]      cx;
    logic [31:0]      cz;
    logic [31:0]      seed;
    logic [AMP_W-1:0] amp;
  } ctx_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } div_ctl_t;

  function automatic logic [31:0] hash_mul(input logic [31:0] a);
    logic [31:0] p;
    p = a * HASH_MUL;
    return p;
  endfunction

  function automatic logic signed [18:0] grad(input logic [2:0] g,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dz);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = g[2] ? 19'(dz) : 19'(dx);
    v = g[2] ? 19'(dx) : 19'(dz);
    return (g[0] ? -u : u) + (g[1] ? -v : v);
  endfunction

  function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                              input logic signed [19:0] b,
                                              input logic [15:0] w);
    logic signed [20:0] diff;
    logic signed [37:0] prod;
    logic signed [21:0] sum;
    diff = 21'(b) - 21'(a);
    prod = diff * $signed({1'b0, w});
    sum  = 22'(a) + $signed(prod[37:16]);
    return sum[19:0];
  endfunction

endpackage

[rtl/fractal_gradient_noise_2d.sv]
// top level of the fractal gradient noise block: config, octave chain, divider, output
//
//  channel | signals                              | direction
//  in      | in_valid in_ready in_coord_x/z       | item in
//  out     | out_valid out_ready out_noise_value  | item out
//  cfg     | cfg_valid cfg_ready cfg_index/data   | register write
//
// one item per cycle while the output is not stalled; the path runs through the octave
// cell chain (8 stages each), the divide prep and the one-bit-per-stage divider
// reset clears all valid bits and loads the register defaults
// a stalled output holds the whole pipeline; in_ready follows
`timescale 1ns / 1ps
module fractal_gradient_noise_2d import fgn_pkg::*; #(
  parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_coord_x,
  input  logic signed [31:0]   in_coord_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_noise_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int TOT_W  = 40 + $clog2(MAX_OCTAVES);
  localparam int ASUM_W = 17 + $clog2(MAX_OCTAVES + 1);
  localparam int DEN_W  = ASUM_W + 2;
  localparam int NUM_W  = TOT_W + 1;

  logic [31:0] seed_r;
  logic [3:0]  octave_count_r;
  logic [15:0] persistence_r;
  logic [CNT_W-1:0] n_eff;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= '0;
      octave_count_r <= 4'd4;
      persistence_r  <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOISE_SEED:   seed_r         <= cfg_data;
        REG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        REG_PERSISTENCE:  persistence_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (octave_count_r == 4'd0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(octave_count_r) > CNT_W'(MAX_OCTAVES)) begin
      n_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      n_eff = CNT_W'(octave_count_r);
    end
  end

  logic              c_vld  [0:MAX_OCTAVES];
  ctx_t              c_ctx  [0:MAX_OCTAVES];
  logic [TOT_W-1:0]  c_tot  [0:MAX_OCTAVES];
  logic [ASUM_W-1:0] c_asum [0:MAX_OCTAVES];

  assign c_vld[0]  = in_valid;
  assign c_ctx[0]  = '{cx: in_coord_x, cz: in_coord_z, seed: seed_r, amp: AMP_ONE};
  assign c_tot[0]  = '0;
  assign c_asum[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fgn_octave_cell #(
      .OCT(i), .COORD_FRAC_BITS(COORD_FRAC_BITS), .TOT_W(TOT_W), .ASUM_W(ASUM_W)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .n_eff(n_eff), .persistence(persistence_r),
      .in_vld(c_vld[i]), .in_ctx(c_ctx[i]), .in_tot(c_tot[i]), .in_asum(c_asum[i]),
      .out_vld(c_vld[i+1]), .out_ctx(c_ctx[i+1]), .out_tot(c_tot[i+1]),
      .out_asum(c_asum[i+1])
    );
  end

  // divide prep: magnitude, rounding offset, overflow check
  logic [2:0]       p_vld_r;
  logic             p1_neg_r, p2_neg_r, p3_neg_r;
  logic [NUM_W-1:0] p1_mag_r, p2_num_r, p3_num_r;
  logic [DEN_W-1:0] p1_den_r, p2_den_r, p3_den_r;
  logic             p3_ovf_r;
  logic [TOT_W-1:0] tot_last;

  assign tot_last = c_tot[MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= '0;
    end else if (en) begin
      p_vld_r <= {p_vld_r[1:0], c_vld[MAX_OCTAVES]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_neg_r <= tot_last[TOT_W-1];
      p1_mag_r <= tot_last[TOT_W-1] ? NUM_W'(-$signed(tot_last)) : NUM_W'(tot_last);
      p1_den_r <= {c_asum[MAX_OCTAVES], 2'b00};
      p2_neg_r <= p1_neg_r;
      p2_num_r <= p1_mag_r + NUM_W'(p1_den_r >> 1);
      p2_den_r <= p1_den_r;
      p3_neg_r <= p2_neg_r;
      p3_num_r <= p2_num_r;
      p3_den_r <= p2_den_r;
      p3_ovf_r <= (p2_num_r >> Q_W) >= NUM_W'(p2_den_r);
    end
  end

  div_ctl_t         d_ctl [0:Q_W];
  logic [NUM_W-1:0] d_rem [0:Q_W];
  logic [DEN_W-1:0] d_den [0:Q_W];
  logic [Q_W-1:0]   d_q   [0:Q_W];

  assign d_ctl[0] = '{valid: p_vld_r[2], neg: p3_neg_r, ovf: p3_ovf_r};
  assign d_rem[0] = p3_num_r;
  assign d_den[0] = p3_den_r;
  assign d_q[0]   = '0;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    fgn_div_cell #(.K(Q_W - 1 - j), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_ctl(d_ctl[j]), .in_rem(d_rem[j]), .in_den(d_den[j]), .in_q(d_q[j]),
      .out_ctl(d_ctl[j+1]), .out_rem(d_rem[j+1]), .out_den(d_den[j+1]), .out_q(d_q[j+1])
    );
  end

  logic [Q_W-1:0] q_clip;
  logic [15:0]    res;
  logic           out_valid_r;
  logic [15:0]    out_noise_r;

  always_comb begin
    if (d_ctl[Q_W].ovf || d_q[Q_W] > Q_LIMIT) begin
      q_clip = Q_LIMIT;
    end else begin
      q_clip = d_q[Q_W];
    end
    if (d_ctl[Q_W].neg) begin
      res = 16'(-q_clip);
    end else if (q_clip == Q_LIMIT) begin
      res = 16'h7fff;
    end else begin
      res = q_clip[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = $signed(out_noise_r);

endmodule

[rtl/fgn_octave_cell.sv]
// one octave cell: lattice hash, gradients, smoothstep blend and weighted accumulate
`timescale 1ns / 1ps
module fgn_octave_cell import fgn_pkg::*; #(
  parameter int OCT             = 0,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int TOT_W           = 43,
  parameter int ASUM_W          = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CNT_W-1:0]  n_eff,
  input  logic [15:0]       persistence,
  input  logic              in_vld,
  input  ctx_t              in_ctx,
  input  logic [TOT_W-1:0]  in_tot,
  input  logic [ASUM_W-1:0] in_asum,
  output logic              out_vld,
  output ctx_t              out_ctx,
  output logic [TOT_W-1:0]  out_tot,
  output logic [ASUM_W-1:0] out_asum
);

  localparam int DEPTH = 8;
  localparam int FB    = COORD_FRAC_BITS;

  logic [DEPTH-1:0] vld_r;
  ctx_t             ctx_r  [0:DEPTH-2];
  logic [TOT_W-1:0] tot_r  [0:DEPTH-2];
  logic [ASUM_W-1:0] asum_r [0:DEPTH-2];

  logic [63:0] sx;
  logic [63:0] sz;
  logic [15:0] fx;
  logic [15:0] fz;

  assign sx = {{32{in_ctx.cx[31]}}, in_ctx.cx} << OCT;
  assign sz = {{32{in_ctx.cz[31]}}, in_ctx.cz} << OCT;

  if (FB >= 16) begin : g_down
    assign fx = sx[FB-1 -: 16];
    assign fz = sz[FB-1 -: 16];
  end else begin : g_up
    assign fx = {sx[FB-1:0], {(16 - FB){1'b0}}};
    assign fz = {sz[FB-1:0], {(16 - FB){1'b0}}};
  end

  logic [31:0] x0_r, x1_r, z0_r, z1_r;
  logic [15:0] fx_r, fz_r;
  logic [31:0] ha0_r, ha1_r, z0b_r, z1b_r, txx_r, tzz_r;
  logic [15:0] fxb_r, fzb_r;
  logic [31:0] hb_r [0:3];
  logic [15:0] fxc_r, fzc_r, wu_r, wv_r;
  logic [31:0] hc_r [0:3];
  logic [15:0] fxd_r, fzd_r, wud_r, wvd_r;
  logic signed [18:0] n_r [0:3];
  logic [15:0] wue_r, wve_r;
  logic signed [19:0] nx0_r, nx1_r;
  logic [15:0] wvf_r;
  logic signed [19:0] v_r;
  ctx_t              octx_r;
  logic [TOT_W-1:0]  otot_r;
  logic [ASUM_W-1:0] oasum_r;

  logic [49:0] pu;
  logic [49:0] pv;
  logic signed [17:0] dx0, dx1, dz0, dz1;
  logic signed [37:0] vprod;
  logic [32:0] amp_prod;
  logic active;

  assign pu = txx_r * (FADE_THREE - {1'b0, fxb_r, 1'b0});
  assign pv = tzz_r * (FADE_THREE - {1'b0, fzb_r, 1'b0});
  assign dx0 = $signed({2'b00, fxd_r});
  assign dx1 = $signed({2'b11, fxd_r});
  assign dz0 = $signed({2'b00, fzd_r});
  assign dz1 = $signed({2'b11, fzd_r});
  assign vprod = v_r * $signed({1'b0, ctx_r[DEPTH-2].amp});
  assign amp_prod = ctx_r[DEPTH-2].amp * persistence;
  assign active = CNT_W'(OCT) < n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0]  <= in_ctx;
      tot_r[0]  <= in_tot;
      asum_r[0] <= in_asum;
      for (int i = 1; i < DEPTH - 1; i++) begin
        ctx_r[i]  <= ctx_r[i-1];
        tot_r[i]  <= tot_r[i-1];
        asum_r[i] <= asum_r[i-1];
      end
      x0_r <= sx[FB+31:FB];
      x1_r <= sx[FB+31:FB] + 32'd1;
      z0_r <= sz[FB+31:FB];
      z1_r <= sz[FB+31:FB] + 32'd1;
      fx_r <= fx;
      fz_r <= fz;
      ha0_r <= hash_mul(ctx_r[0].seed ^ x0_r);
      ha1_r <= hash_mul(ctx_r[0].seed ^ x1_r);
      z0b_r <= z0_r;
      z1b_r <= z1_r;
      txx_r <= fx_r * fx_r;
      tzz_r <= fz_r * fz_r;
      fxb_r <= fx_r;
      fzb_r <= fz_r;
      hb_r[0] <= hash_mul(ha0_r ^ z0b_r);
      hb_r[1] <= hash_mul(ha1_r ^ z0b_r);
      hb_r[2] <= hash_mul(ha0_r ^ z1b_r);
      hb_r[3] <= hash_mul(ha1_r ^ z1b_r);
      wu_r  <= pu[47:32];
      wv_r  <= pv[47:32];
      fxc_r <= fxb_r;
      fzc_r <= fzb_r;
      for (int k = 0; k < 4; k++) begin
        hc_r[k] <= hash_mul(hb_r[k] ^ 32'($signed(hb_r[k]) >>> 15));
      end
      fxd_r <= fxc_r;
      fzd_r <= fzc_r;
      wud_r <= wu_r;
      wvd_r <= wv_r;
      n_r[0] <= grad(hc_r[0][2:0], dx0, dz0);
      n_r[1] <= grad(hc_r[1][2:0], dx1, dz0);
      n_r[2] <= grad(hc_r[2][2:0], dx0, dz1);
      n_r[3] <= grad(hc_r[3][2:0], dx1, dz1);
      wue_r <= wud_r;
      wve_r <= wvd_r;
      nx0_r <= lerp(20'(n_r[0]), 20'(n_r[1]), wue_r);
      nx1_r <= lerp(20'(n_r[2]), 20'(n_r[3]), wue_r);
      wvf_r <= wve_r;
      v_r   <= lerp(nx0_r, nx1_r, wvf_r);
      octx_r.cx   <= ctx_r[DEPTH-2].cx;
      octx_r.cz   <= ctx_r[DEPTH-2].cz;
      octx_r.seed <= ctx_r[DEPTH-2].seed + 32'd1;
      octx_r.amp  <= amp_prod[32:16];
      if (active) begin
        otot_r  <= tot_r[DEPTH-2] + TOT_W'(vprod);
        oasum_r <= asum_r[DEPTH-2] + ASUM_W'(ctx_r[DEPTH-2].amp);
      end else begin
        otot_r  <= tot_r[DEPTH-2];
        oasum_r <= asum_r[DEPTH-2];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_ctx  = octx_r;
  assign out_tot  = otot_r;
  assign out_asum = oasum_r;

endmodule

[rtl/fgn_div_cell.sv]
// one restoring division step producing a single quotient bit
`timescale 1ns / 1ps
module fgn_div_cell import fgn_pkg::*; #(
  parameter int K     = 0,
  parameter int NUM_W = 44,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_ctl_t         in_ctl,
  input  logic [NUM_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  logic [Q_W-1:0]   in_q,
  output div_ctl_t         out_ctl,
  output logic [NUM_W-1:0] out_rem,
  output logic [DEN_W-1:0] out_den,
  output logic [Q_W-1:0]   out_q
);

  logic [NUM_W-1:0] trial;
  logic             take;
  div_ctl_t         ctl_r;
  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q_r;

  assign trial = NUM_W'(in_den) << K;
  assign take  = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= take ? in_rem - trial : in_rem;
      den_r <= in_den;
      q_r   <= in_q | (take ? (Q_W'(1) << K) : '0);
    end
  end

  assign out_ctl = ctl_r;
  assign out_rem = rem_r;
  assign out_den = den_r;
  assign out_q   = q_r;

endmodule
